@@ rtl/core/trm_pkg.sv @@
package trm_pkg;

  localparam int NUM_REGS    = 16;
  localparam int MEM_WORDS   = 1024;
  localparam int STACK_DEPTH = 8;
  localparam int REG_AW      = $clog2(NUM_REGS);
  localparam int MEM_AW      = $clog2(MEM_WORDS);
  localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int PC_W        = 11;
  localparam logic [PC_W-1:0] PC_LIMIT = 11'd1024;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
    OP_STORE = 5'd4, OP_LOAD = 5'd5,  OP_AFC  = 5'd6,  OP_EQU  = 5'd7,
    OP_INF  = 5'd8,  OP_INFE = 5'd9,  OP_SUP  = 5'd10, OP_SUPE = 5'd11,
    OP_JMPC = 5'd12, OP_CALL = 5'd13, OP_RET  = 5'd14, OP_PRT  = 5'd15,
    OP_JMP  = 5'd16
  } op_t;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0, ERR_REG   = 3'd1, ERR_ADDR  = 3'd2, ERR_OVER = 3'd3,
    ERR_UNDER = 3'd4, ERR_OPC   = 3'd5, ERR_TGT   = 3'd6
  } err_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_MEM, ST_DIV, ST_OUT
  } state_t;

endpackage

@@ rtl/core/toy_register_machine_execute_core.sv @@
// Executes one instruction per item; the result waits in an output register.
// Register ops, jumps, stores, returns and decode errors give their result straight from the
// execute state; loads, calls and prints first do one data memory read; divide iterates, one
// quotient bit a cycle. The next item is accepted once the result has been taken.
// Reset (rst_n low, synchronous) clears pc, registers and stack level, then a clearing pass
// zeroes all 1024 words of the data memory.
module toy_register_machine_execute_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cmd[4:0], operand_a[14:5], operand_b[30:15]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // next_pc[10:0], print_valid[11],
                                  // print_reg_value[43:12], print_mem_value[75:44],
                                  // error_code[78:76]
);

  trm_pkg::state_t state_r, state_nxt;

  // architectural state
  logic [trm_pkg::PC_W-1:0]  pc_r;
  logic [31:0]               regs_r [trm_pkg::NUM_REGS];
  logic [trm_pkg::LVL_W-1:0] lvl_r;
  logic [9:0]                stk_r [trm_pkg::STACK_DEPTH];
  logic [31:0]               dmem [trm_pkg::MEM_WORDS];
  logic [31:0]               dmem_q;

  // captured instruction
  logic [4:0]  cmd_r;
  logic [9:0]  a_r;
  logic [31:0] b_r;
  logic [31:0] x_r, y_r;

  // clearing pass
  logic [trm_pkg::MEM_AW:0] clr_r;

  // divider
  logic [5:0]  dcnt_r;
  logic [31:0] dq_r, drem_r, dmy_r;
  logic        dneg_r;

  // output register
  logic                     ov_r;
  logic [trm_pkg::PC_W-1:0] o_pc_r;
  logic                     o_pv_r;
  logic [31:0]              o_preg_r, o_pmem_r;
  logic [2:0]               o_err_r;

  logic [4:0]  in_cmd;
  logic [9:0]  in_a;
  logic [15:0] in_b;
  assign in_cmd = in_tdata[4:0];
  assign in_a   = in_tdata[14:5];
  assign in_b   = in_tdata[30:15];

  logic acc;
  assign in_tready = (state_r == trm_pkg::ST_IDLE) && !ov_r;
  assign acc = in_tvalid && in_tready;

  // decode in EXEC
  logic b_reg_ok, a_reg_ok, b_mem_ok, a_mem_ok, x_mem_ok, y_mem_ok;
  logic [trm_pkg::PC_W-1:0] pc_inc;
  assign b_reg_ok = (b_r < 32'(trm_pkg::NUM_REGS));
  assign a_reg_ok = (32'(a_r) < 32'(trm_pkg::NUM_REGS));
  assign b_mem_ok = (b_r < 32'(trm_pkg::MEM_WORDS));
  assign a_mem_ok = (32'(a_r) < 32'(trm_pkg::MEM_WORDS));
  assign x_mem_ok = (x_r < 32'(trm_pkg::MEM_WORDS));
  assign y_mem_ok = (y_r < 32'(trm_pkg::MEM_WORDS));
  assign pc_inc   = (pc_r >= trm_pkg::PC_LIMIT) ? trm_pkg::PC_LIMIT : pc_r + 1'b1;

  // top of stack entry for a return
  logic [trm_pkg::LVL_W-1:0] lvl_dec;
  assign lvl_dec = lvl_r - 1'b1;

  logic [31:0] mul_w;
  assign mul_w = x_r * y_r;

  // memory address for the read stage
  logic [trm_pkg::MEM_AW-1:0] rd_addr;
  always_comb begin
    unique case (cmd_r)
      trm_pkg::OP_LOAD: rd_addr = y_r[trm_pkg::MEM_AW-1:0];
      trm_pkg::OP_CALL: rd_addr = a_r[trm_pkg::MEM_AW-1:0];
      default:          rd_addr = b_r[trm_pkg::MEM_AW-1:0];
    endcase
  end

  // result of EXEC step (non-memory)
  logic [2:0]  ex_err;
  logic        ex_wr, ex_mem, ex_div, ex_st;
  logic [31:0] ex_val;
  logic [trm_pkg::PC_W-1:0] ex_pc;
  logic signed [31:0] xs, ys;
  assign xs = x_r;
  assign ys = y_r;
  always_comb begin
    ex_err = trm_pkg::ERR_OK;
    ex_wr  = 1'b0;
    ex_mem = 1'b0;
    ex_div = 1'b0;
    ex_st  = 1'b0;
    ex_val = '0;
    ex_pc  = pc_inc;
    if (cmd_r <= 5'(trm_pkg::OP_JMPC) && cmd_r != 5'(trm_pkg::OP_AFC)) begin
      if (!b_reg_ok || (cmd_r != 5'(trm_pkg::OP_JMPC) && !a_reg_ok)) begin
        ex_err = trm_pkg::ERR_REG;
      end else begin
        unique case (cmd_r)
          trm_pkg::OP_ADD: begin ex_wr = 1'b1; ex_val = x_r + y_r; end
          trm_pkg::OP_SUB: begin ex_wr = 1'b1; ex_val = x_r - y_r; end
          trm_pkg::OP_MUL: begin ex_wr = 1'b1; ex_val = mul_w; end
          trm_pkg::OP_DIV: ex_div = 1'b1;
          trm_pkg::OP_STORE: begin
            if (!x_mem_ok) ex_err = trm_pkg::ERR_ADDR; else ex_st = 1'b1;
          end
          trm_pkg::OP_LOAD: begin
            if (!y_mem_ok) ex_err = trm_pkg::ERR_ADDR; else ex_mem = 1'b1;
          end
          trm_pkg::OP_JMPC: if (y_r == 32'hFFFF_FFFF) ex_pc = 11'(a_r) + 1'b1;
          trm_pkg::OP_EQU:  begin ex_wr = 1'b1; ex_val = (xs == ys) ? 32'd1 : '1; end
          trm_pkg::OP_INF:  begin ex_wr = 1'b1; ex_val = (xs <  ys) ? 32'd1 : '1; end
          trm_pkg::OP_INFE: begin ex_wr = 1'b1; ex_val = (xs <= ys) ? 32'd1 : '1; end
          trm_pkg::OP_SUP:  begin ex_wr = 1'b1; ex_val = (xs >  ys) ? 32'd1 : '1; end
          default:          begin ex_wr = 1'b1; ex_val = (xs >= ys) ? 32'd1 : '1; end
        endcase
      end
    end else begin
      unique case (cmd_r)
        trm_pkg::OP_AFC: begin
          if (!a_reg_ok) ex_err = trm_pkg::ERR_REG;
          else begin ex_wr = 1'b1; ex_val = b_r; end
        end
        trm_pkg::OP_CALL: begin
          if (!a_mem_ok) ex_err = trm_pkg::ERR_ADDR;
          else if (32'(lvl_r) >= 32'(trm_pkg::STACK_DEPTH)) ex_err = trm_pkg::ERR_OVER;
          else ex_mem = 1'b1;
        end
        trm_pkg::OP_RET: begin
          if (lvl_r == '0) ex_err = trm_pkg::ERR_UNDER;
          else ex_pc = 11'(stk_r[lvl_dec[trm_pkg::STK_AW-1:0]]) + 1'b1;
        end
        trm_pkg::OP_PRT: begin
          if (!a_reg_ok) ex_err = trm_pkg::ERR_REG;
          else if (!b_mem_ok) ex_err = trm_pkg::ERR_ADDR;
          else ex_mem = 1'b1;
        end
        trm_pkg::OP_JMP: ex_pc = 11'(a_r) + 1'b1;
        default: ex_err = trm_pkg::ERR_OPC;
      endcase
    end
    if (ex_err != trm_pkg::ERR_OK) ex_pc = pc_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      trm_pkg::ST_CLEAR: if (clr_r == (trm_pkg::MEM_AW+1)'(trm_pkg::MEM_WORDS - 1))
                           state_nxt = trm_pkg::ST_IDLE;
      trm_pkg::ST_IDLE:  if (acc) state_nxt = trm_pkg::ST_EXEC;
      trm_pkg::ST_EXEC:  begin
        if (ex_mem) state_nxt = trm_pkg::ST_MEM;
        else if (ex_div) state_nxt = trm_pkg::ST_DIV;
        else state_nxt = trm_pkg::ST_IDLE;
      end
      trm_pkg::ST_MEM:   state_nxt = trm_pkg::ST_IDLE;
      trm_pkg::ST_DIV:   if (dcnt_r == 6'd33) state_nxt = trm_pkg::ST_IDLE;
      default:           state_nxt = trm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= trm_pkg::ST_CLEAR;
    else state_r <= state_nxt;
  end

  // data memory: one write port, one registered read port
  logic dm_we;
  logic [trm_pkg::MEM_AW-1:0] dm_wa;
  logic [31:0] dm_wd;
  always_comb begin
    dm_we = 1'b0;
    dm_wa = x_r[trm_pkg::MEM_AW-1:0];
    dm_wd = y_r;
    if (state_r == trm_pkg::ST_CLEAR) begin
      dm_we = 1'b1;
      dm_wa = clr_r[trm_pkg::MEM_AW-1:0];
      dm_wd = '0;
    end else if (state_r == trm_pkg::ST_EXEC && ex_st) begin
      dm_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) dmem[dm_wa] <= dm_wd;
    dmem_q <= dmem[rd_addr];
  end

  // clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (state_r == trm_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
  end

  // instruction capture and operand fetch
  logic signed [31:0] bext;
  assign bext = 32'(signed'(in_b));
  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r <= in_cmd;
      a_r   <= in_a;
      b_r   <= bext;
      x_r   <= (in_cmd == 5'(trm_pkg::OP_JMPC)) ? 32'd0
               : regs_r[in_a[trm_pkg::REG_AW-1:0]];
      y_r   <= regs_r[bext[trm_pkg::REG_AW-1:0]];
    end
  end

  // iterative divide on magnitudes
  logic [32:0] dtrial;
  assign dtrial = {drem_r, dq_r[31]} - {1'b0, dmy_r};
  always_ff @(posedge clk) begin
    if (state_r == trm_pkg::ST_EXEC) begin
      dcnt_r <= '0;
      dq_r   <= x_r[31] ? 32'd0 - x_r : x_r;
      dmy_r  <= y_r[31] ? 32'd0 - y_r : y_r;
      drem_r <= '0;
      dneg_r <= x_r[31] ^ y_r[31];
    end else if (state_r == trm_pkg::ST_DIV && dcnt_r < 6'd32) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (!dtrial[32]) begin
        drem_r <= dtrial[31:0];
        dq_r   <= {dq_r[30:0], 1'b1};
      end else begin
        drem_r <= {drem_r[30:0], dq_r[31]};
        dq_r   <= {dq_r[30:0], 1'b0};
      end
    end else if (state_r == trm_pkg::ST_DIV) begin
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  logic [31:0] div_res;
  assign div_res = (dmy_r == '0) ? 32'd0 : (dneg_r ? 32'd0 - dq_r : dq_r);

  // register file, stack and pc updates
  logic rf_we;
  logic [31:0] rf_wd;
  always_comb begin
    rf_we = 1'b0;
    rf_wd = ex_val;
    if (state_r == trm_pkg::ST_EXEC && ex_wr) rf_we = 1'b1;
    else if (state_r == trm_pkg::ST_MEM && cmd_r == 5'(trm_pkg::OP_LOAD)) begin
      rf_we = 1'b1; rf_wd = dmem_q;
    end else if (state_r == trm_pkg::ST_DIV && dcnt_r == 6'd33) begin
      rf_we = 1'b1; rf_wd = div_res;
    end
  end

  logic call_ok;
  assign call_ok = (dmem_q < 32'(trm_pkg::PC_LIMIT)) && (b_r < 32'(trm_pkg::PC_LIMIT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < trm_pkg::NUM_REGS; i++) regs_r[i] <= '0;
    end else if (rf_we) begin
      regs_r[a_r[trm_pkg::REG_AW-1:0]] <= rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == trm_pkg::ST_MEM && cmd_r == 5'(trm_pkg::OP_CALL) && call_ok)
      stk_r[lvl_r[trm_pkg::STK_AW-1:0]] <= b_r[9:0];
  end

  // result assembly
  logic res_v;
  logic [trm_pkg::PC_W-1:0] res_pc;
  logic res_pv;
  logic [31:0] res_preg, res_pmem;
  logic [2:0] res_err;
  always_comb begin
    res_v = 1'b0;
    res_pc = ex_pc;
    res_pv = 1'b0;
    res_preg = '0;
    res_pmem = '0;
    res_err = ex_err;
    unique case (state_r)
      trm_pkg::ST_EXEC: res_v = !ex_mem && !ex_div;
      trm_pkg::ST_MEM: begin
        res_v = 1'b1;
        res_err = trm_pkg::ERR_OK;
        res_pc = pc_inc;
        if (cmd_r == 5'(trm_pkg::OP_CALL)) begin
          if (call_ok) res_pc = dmem_q[10:0] + 1'b1;
          else begin res_err = trm_pkg::ERR_TGT; res_pc = pc_r; end
        end else if (cmd_r == 5'(trm_pkg::OP_PRT)) begin
          res_pv = 1'b1;
          res_preg = x_r;
          res_pmem = dmem_q;
        end
      end
      trm_pkg::ST_DIV: begin
        res_v = (dcnt_r == 6'd33);
        res_err = trm_pkg::ERR_OK;
        res_pc = pc_inc;
      end
      default: res_v = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      lvl_r <= '0;
    end else if (res_v) begin
      pc_r <= res_pc;
      if (res_err == trm_pkg::ERR_OK) begin
        if (cmd_r == 5'(trm_pkg::OP_CALL)) lvl_r <= lvl_r + 1'b1;
        else if (cmd_r == 5'(trm_pkg::OP_RET)) lvl_r <= lvl_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (res_v) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      o_pc_r   <= res_pc;
      o_pv_r   <= res_pv;
      o_preg_r <= res_preg;
      o_pmem_r <= res_pmem;
      o_err_r  <= res_err;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, o_err_r, o_pmem_r, o_preg_r, o_pv_r, o_pc_r};

`ifndef SYNTHESIS
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !ov_r) else $error("accept with pending result");
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(lvl_r) <= 32'(trm_pkg::STACK_DEPTH)) else $error("stack level out of range");
  a_err_pc: assert property (@(posedge clk) disable iff (!rst_n)
    res_v && res_err != trm_pkg::ERR_OK |-> res_pc == pc_r) else $error("pc moved on error");
  a_err_print: assert property (@(posedge clk) disable iff (!rst_n)
    res_v && res_pv |-> res_err == trm_pkg::ERR_OK) else $error("print on error");
`endif

endmodule
